// ===== design/smpq_pkg.sv =====
// Shared types and constants of the sorted minimum priority queue.
package smpq_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int TAG_BITS_DEF = 16;

	localparam int TAG_IN_W = 16;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 7;
	localparam int TOTAL_W  = 32;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_RM_WAIT,
		S_RESP
	} state_t;

	typedef struct packed {
		status_t             status;
		logic [TAG_IN_W-1:0] removed_tag;
		logic [OCC_W-1:0]    occupancy;
		logic [TOTAL_W-1:0]  insert_total;
		logic [TOTAL_W-1:0]  remove_total;
	} res_t;

endpackage

// ===== design/smpq_if.sv =====
// Request and response channel interfaces of the sorted minimum priority queue.
interface smpq_in_if;
	import smpq_pkg::*;

	logic                valid;
	logic                ready;
	logic                op;
	logic [TAG_IN_W-1:0] tag;

	modport source (output valid, output op, output tag, input ready);
	modport sink (input valid, input op, input tag, output ready);
endinterface

interface smpq_out_if;
	import smpq_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [TAG_IN_W-1:0] removed_tag;
	logic [OCC_W-1:0]    occupancy;
	logic [TOTAL_W-1:0]  insert_total;
	logic [TOTAL_W-1:0]  remove_total;

	modport source (output valid, output status, output removed_tag, output occupancy,
		output insert_total, output remove_total, input ready);
	modport sink (input valid, input status, input removed_tag, input occupancy,
		input insert_total, input remove_total, output ready);
endinterface

// ===== design/smpq_store.sv =====
// Tag store: one write port and one registered read port.
module smpq_store #(
	parameter int CAPACITY = smpq_pkg::CAPACITY_DEF,
	parameter int TAG_BITS = smpq_pkg::TAG_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [$clog2(CAPACITY)-1:0] waddr,
	input  logic [TAG_BITS-1:0]         wdata,
	input  logic                        re,
	input  logic [$clog2(CAPACITY)-1:0] raddr,
	output logic [TAG_BITS-1:0]         rdata
);
	logic [TAG_BITS-1:0] mem [CAPACITY];
	logic [TAG_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== design/smpq_ctrl.sv =====
// Sequencer of the queue: ring pointers, shift-and-compare insert walk, counters.
module smpq_ctrl #(
	parameter int CAPACITY = smpq_pkg::CAPACITY_DEF,
	parameter int TAG_BITS = smpq_pkg::TAG_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	smpq_in_if.sink                     req,
	output logic                        mem_we,
	output logic [$clog2(CAPACITY)-1:0] mem_waddr,
	output logic [TAG_BITS-1:0]         mem_wdata,
	output logic                        mem_re,
	output logic [$clog2(CAPACITY)-1:0] mem_raddr,
	input  logic [TAG_BITS-1:0]         mem_rdata,
	output logic                        res_valid,
	input  logic                        res_ready,
	output smpq_pkg::res_t              res
);
	import smpq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

	state_t                state_q, state_d;
	logic [TAG_BITS-1:0]   tag_q;
	logic [AW-1:0]         head_q, tail_q, wp_q;
	logic [CW-1:0]         count_q, rem_q;
	logic [TOTAL_W-1:0]    ins_tot_q, rm_tot_q;
	status_t               status_q;
	logic [TAG_IN_W-1:0]   removed_q;

	logic          accept;
	logic          full, empty, rem_zero, greater, ins_finish;
	logic [AW-1:0] prev_wp, head_inc, tail_inc;

	assign accept   = req.valid && req.ready;
	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign rem_zero = (rem_q == '0);
	// the one shared compare: held entry against the tag being inserted
	assign greater  = (mem_rdata > tag_q);
	assign prev_wp  = (wp_q == '0) ? LAST_IDX : wp_q - 1'b1;
	assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
	assign ins_finish = (state_q == S_INS_RD && rem_zero) ||
		(state_q == S_INS_CMP && !greater);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.op == OP_REMOVE) begin
						state_d = empty ? S_RESP : S_RM_WAIT;
					end else begin
						state_d = full ? S_RESP : S_INS_RD;
					end
				end
			end
			S_INS_RD: begin
				state_d = rem_zero ? S_RESP : S_INS_CMP;
			end
			S_INS_CMP: begin
				state_d = greater ? S_INS_RD : S_RESP;
			end
			S_RM_WAIT: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		res_valid = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = prev_wp;
		mem_we    = 1'b0;
		mem_waddr = wp_q;
		mem_wdata = tag_q;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				mem_raddr = head_q;
				mem_re    = req.valid && (req.op == OP_REMOVE) && !empty;
			end
			S_INS_RD: begin
				mem_re = !rem_zero;
				mem_we = rem_zero;
			end
			S_INS_CMP: begin
				// shift the larger entry up one slot, or drop the tag in place
				mem_we    = 1'b1;
				mem_wdata = greater ? mem_rdata : tag_q;
			end
			S_RESP: begin
				res_valid = 1'b1;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			tail_q    <= '0;
			wp_q      <= '0;
			count_q   <= '0;
			rem_q     <= '0;
			ins_tot_q <= '0;
			rm_tot_q  <= '0;
			status_q  <= ST_DONE;
			removed_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && accept) begin
				removed_q <= '0;
				wp_q      <= tail_q;
				rem_q     <= count_q;
				if (req.op == OP_REMOVE) begin
					status_q <= empty ? ST_EMPTY : ST_DONE;
				end else begin
					status_q <= full ? ST_FULL : ST_DONE;
				end
			end
			if (state_q == S_INS_CMP && greater) begin
				wp_q  <= prev_wp;
				rem_q <= rem_q - 1'b1;
			end
			if (ins_finish) begin
				tail_q    <= tail_inc;
				count_q   <= count_q + 1'b1;
				ins_tot_q <= ins_tot_q + 1'b1;
			end
			if (state_q == S_RM_WAIT) begin
				removed_q <= TAG_IN_W'(mem_rdata);
				head_q    <= head_inc;
				count_q   <= count_q - 1'b1;
				rm_tot_q  <= rm_tot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			tag_q <= TAG_BITS'(req.tag);
		end
	end

	always_comb begin
		res.status       = status_q;
		res.removed_tag  = removed_q;
		res.occupancy    = OCC_W'(count_q);
		res.insert_total = ins_tot_q;
		res.remove_total = rm_tot_q;
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above capacity");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.op == OP_INSERT && full) |=>
		(count_q == $past(count_q) && status_q == ST_FULL))
		else $error("insert on full queue changed state");

	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_INS_RD || state_q == S_INS_CMP))
		else $error("store written outside insert walk");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_RD || state_q == S_INS_CMP) |-> rem_q <= count_q)
		else $error("insert walk passed the head");

	a_remove_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RM_WAIT) |=> count_q == $past(count_q) - 1'b1)
		else $error("remove did not drop one entry");
`endif
endmodule

// ===== design/sorted_min_priority_queue.sv =====
// Sorted minimum priority queue: the store held as a ring in ascending order,
// the smallest tag at the head. A remove reads the head and advances it, passing
// through a wait state for the registered read before its result; a remove on an
// empty queue or an insert on a full one goes straight to the result. An insert
// walks back from the tail through the single read port of the store, each step a
// read and then one compare and one shift write, until a held tag is not greater
// than the new one or every held tag is walked, and then writes the new tag in place.
// One item is in work at a time; the result register lets the next item be
// accepted while a finished result still waits on the response channel.
module sorted_min_priority_queue #(
	parameter int CAPACITY = smpq_pkg::CAPACITY_DEF,
	parameter int TAG_BITS = smpq_pkg::TAG_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	smpq_in_if.sink     req,
	smpq_out_if.source  rsp
);
	import smpq_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	logic                mem_we, mem_re;
	logic [AW-1:0]       mem_waddr, mem_raddr;
	logic [TAG_BITS-1:0] mem_wdata, mem_rdata;
	logic                res_valid, res_ready;
	res_t                res;
	logic                out_valid_q;
	res_t                out_q;

	smpq_store #(
		.CAPACITY (CAPACITY),
		.TAG_BITS (TAG_BITS)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	smpq_ctrl #(
		.CAPACITY (CAPACITY),
		.TAG_BITS (TAG_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_q.status;
	assign rsp.removed_tag  = out_q.removed_tag;
	assign rsp.occupancy    = out_q.occupancy;
	assign rsp.insert_total = out_q.insert_total;
	assign rsp.remove_total = out_q.remove_total;
endmodule
